FILE: hw/rtl/spcol_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spcol_pkg
// Shared types and constants of the sprite pixel collision block.
// ----------------------------------------------------------------------------
package spcol_pkg;

    localparam int MAX_SPRITE = 256;
    localparam int SIZE_W     = 9;
    localparam int FRAME_W    = 12;
    localparam int POS_W      = 16;
    localparam int PIX_W      = 32;
    localparam int CNT_W      = 17;
    localparam int DIV_STEPS  = FRAME_W;
    localparam int DCNT_W     = $clog2(DIV_STEPS);
    localparam int IN_DATA_W  = 152;
    localparam int OUT_DATA_W = 88;

    localparam logic OP_BEGIN = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    localparam logic [2:0] REG_WIDTH_A  = 3'd0;
    localparam logic [2:0] REG_HEIGHT_A = 3'd1;
    localparam logic [2:0] REG_WIDTH_B  = 3'd2;
    localparam logic [2:0] REG_HEIGHT_B = 3'd3;
    localparam logic [2:0] REG_ACROSS_A = 3'd4;
    localparam logic [2:0] REG_ACROSS_B = 3'd5;
    localparam logic [2:0] REG_KEY_A    = 3'd6;
    localparam logic [2:0] REG_KEY_B    = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_DIV,
        ST_MUL,
        ST_EMIT,
        ST_SCAN
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic calc;
        logic div_step;
        logic mul;
        logic load_miss;
        logic load_win;
        logic pix;
    } cmd_t;

    typedef struct packed {
        logic miss;
        logic div_last;
        logic out_free;
        logic pix_end;
    } sts_t;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
        return (v > SIZE_W'(MAX_SPRITE)) ? SIZE_W'(MAX_SPRITE) : v;
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/spcol_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spcol_div
// Restoring divider, one quotient bit per step, frame number by frames across.
// ----------------------------------------------------------------------------
module spcol_div
    import spcol_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               load,
    input  wire logic               step,
    input  wire logic [FRAME_W-1:0] dividend,
    input  wire logic [SIZE_W-1:0]  divisor,
    output logic      [FRAME_W-1:0] quo,
    output logic      [SIZE_W-1:0]  rem
);

    logic [FRAME_W-1:0] q_reg, q_next;
    logic [SIZE_W-1:0]  r_reg, r_next;
    logic [SIZE_W-1:0]  d_reg;
    logic [SIZE_W:0]    trial;
    logic               ge;

    always_comb
    begin
        trial  = {r_reg, q_reg[FRAME_W-1]};
        ge     = (trial >= {1'b0, d_reg});
        r_next = ge ? SIZE_W'(trial - {1'b0, d_reg}) : trial[SIZE_W-1:0];
        q_next = {q_reg[FRAME_W-2:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (step)
        begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    assign quo = q_reg;
    assign rem = r_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/spcol_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spcol_ctrl
// Sequencer: begin setup (geometry, divide, multiply, emit) and pixel scan.
// ----------------------------------------------------------------------------
module spcol_ctrl
    import spcol_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    input  wire logic in_op,
    output logic      in_ready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    ctrl_state_t state_reg, state_next;
    logic        acc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        acc        = 1'b0;
        unique case (state_reg)
            ST_IDLE, ST_SCAN:
            begin
                in_ready = sts.out_free;
                acc      = in_valid && sts.out_free;
                if (acc)
                begin
                    if (in_op == OP_BEGIN)
                    begin
                        cmd.capture = 1'b1;
                        state_next  = ST_CALC;
                    end
                    else if (state_reg == ST_SCAN)
                    begin
                        cmd.pix = 1'b1;
                        if (sts.pix_end)
                            state_next = ST_IDLE;
                    end
                end
            end
            ST_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    if (sts.miss)
                    begin
                        cmd.load_miss = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        cmd.load_win = 1'b1;
                        state_next   = ST_SCAN;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: hw/rtl/spcol_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spcol_dp
// Datapath: config registers, overlap geometry, frame offsets, pixel scan
// and the output word register.
// ----------------------------------------------------------------------------
module spcol_dp
    import spcol_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wen,
    input  wire logic [2:0]            cfg_index,
    input  wire logic [31:0]           cfg_data,
    input  wire logic [IN_DATA_W-1:0]  in_data,
    input  wire cmd_t                  cmd,
    output sts_t                       sts,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [OUT_DATA_W-1:0]      out_data,
    output logic                       out_user
);

    localparam int SW = POS_W + 2;

    logic [SIZE_W-1:0] wa_reg, ha_reg, wb_reg, hb_reg, fxa_reg, fxb_reg;
    logic [PIX_W-1:0]  key_a_reg, key_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wa_reg    <= SIZE_W'(16);
            ha_reg    <= SIZE_W'(16);
            wb_reg    <= SIZE_W'(16);
            hb_reg    <= SIZE_W'(16);
            fxa_reg   <= SIZE_W'(1);
            fxb_reg   <= SIZE_W'(1);
            key_a_reg <= '0;
            key_b_reg <= '0;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                REG_WIDTH_A:  wa_reg    <= cfg_data[SIZE_W-1:0];
                REG_HEIGHT_A: ha_reg    <= cfg_data[SIZE_W-1:0];
                REG_WIDTH_B:  wb_reg    <= cfg_data[SIZE_W-1:0];
                REG_HEIGHT_B: hb_reg    <= cfg_data[SIZE_W-1:0];
                REG_ACROSS_A: fxa_reg   <= cfg_data[SIZE_W-1:0];
                REG_ACROSS_B: fxb_reg   <= cfg_data[SIZE_W-1:0];
                REG_KEY_A:    key_a_reg <= cfg_data[PIX_W-1:0];
                REG_KEY_B:    key_b_reg <= cfg_data[PIX_W-1:0];
                default:      ;
            endcase
        end
    end

    // captured begin word
    logic [POS_W-1:0]   xa_reg, ya_reg, xb_reg, yb_reg;
    logic [FRAME_W-1:0] fa_reg, fb_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            xa_reg <= in_data[15:0];
            ya_reg <= in_data[31:16];
            fa_reg <= in_data[43:32];
            xb_reg <= in_data[59:44];
            yb_reg <= in_data[75:60];
            fb_reg <= in_data[87:76];
        end
    end

    // geometry
    logic signed [SW-1:0] sxa, sya, sxb, syb, lx, ly, rx, ry;
    logic [SIZE_W-1:0]    wa, ha, wb, hb, lw, lh, rw, rh, lacr, racr;
    logic                 box_miss, left_b;
    logic [SW-1:0]        dx, dy, tw, th;
    logic [SIZE_W-1:0]    iw, ih;
    logic [POS_W-1:0]     lpy, rpy;

    always_comb
    begin
        sxa = SW'(signed'(xa_reg));
        sya = SW'(signed'(ya_reg));
        sxb = SW'(signed'(xb_reg));
        syb = SW'(signed'(yb_reg));
        wa  = clamp_size(wa_reg);
        ha  = clamp_size(ha_reg);
        wb  = clamp_size(wb_reg);
        hb  = clamp_size(hb_reg);
        box_miss = (sya > syb + $signed({9'd0, hb})) || (sya + $signed({9'd0, ha}) < syb) ||
                   (sxa + $signed({9'd0, wa}) < sxb) || (sxa > sxb + $signed({9'd0, wb}));
        left_b = !(sxb > sxa);
        lx = left_b ? sxb : sxa;
        ly = left_b ? syb : sya;
        rx = left_b ? sxa : sxb;
        ry = left_b ? sya : syb;
        lw = left_b ? wb : wa;
        lh = left_b ? hb : ha;
        rw = left_b ? wa : wb;
        rh = left_b ? ha : hb;
        lacr = left_b ? fxb_reg : fxa_reg;
        racr = left_b ? fxa_reg : fxb_reg;
        if (lacr == '0)
            lacr = SIZE_W'(1);
        if (racr == '0)
            racr = SIZE_W'(1);
        dx = SW'(rx - lx);
        tw = SW'({9'd0, lw}) - dx;
        iw = (tw > SW'({9'd0, rw})) ? rw : tw[SIZE_W-1:0];
        if (ly > ry)
        begin
            dy  = SW'(ly - ry);
            lpy = '0;
            rpy = dy[POS_W-1:0];
            th  = SW'({9'd0, rh}) - dy;
            ih  = (th > SW'({9'd0, lh})) ? lh : th[SIZE_W-1:0];
        end
        else
        begin
            dy  = SW'(ry - ly);
            rpy = '0;
            lpy = dy[POS_W-1:0];
            th  = SW'({9'd0, lh}) - dy;
            ih  = (th > SW'({9'd0, rh})) ? rh : th[SIZE_W-1:0];
        end
    end

    logic                 miss_reg, left_b_reg;
    logic [SIZE_W-1:0]    iw_reg, ih_reg, lw_reg, lh_reg, rw_reg, rh_reg;
    logic [POS_W-1:0]     dx_reg, lpy_reg, rpy_reg;
    logic [DCNT_W-1:0]    dcnt_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.calc)
        begin
            miss_reg   <= box_miss;
            left_b_reg <= left_b;
            iw_reg     <= iw;
            ih_reg     <= ih;
            lw_reg     <= lw;
            lh_reg     <= lh;
            rw_reg     <= rw;
            rh_reg     <= rh;
            dx_reg     <= dx[POS_W-1:0];
            lpy_reg    <= lpy;
            rpy_reg    <= rpy;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dcnt_reg <= '0;
        else if (cmd.calc)
            dcnt_reg <= '0;
        else if (cmd.div_step)
            dcnt_reg <= dcnt_reg + DCNT_W'(1);
    end

    logic [FRAME_W-1:0] lquo, rquo;
    logic [SIZE_W-1:0]  lrem, rrem;

    spcol_div u_ldiv (
        .clk      (clk),
        .load     (cmd.calc),
        .step     (cmd.div_step),
        .dividend (left_b ? fb_reg : fa_reg),
        .divisor  (lacr),
        .quo      (lquo),
        .rem      (lrem)
    );

    spcol_div u_rdiv (
        .clk      (clk),
        .load     (cmd.calc),
        .step     (cmd.div_step),
        .dividend (left_b ? fa_reg : fb_reg),
        .divisor  (racr),
        .quo      (rquo),
        .rem      (rrem)
    );

    logic [POS_W-1:0] lsx_reg, lsy_reg, rsx_reg, rsy_reg;
    logic [CNT_W-1:0] area_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            lsx_reg  <= POS_W'(18'(lrem) * 18'(lw_reg) + 18'(dx_reg));
            lsy_reg  <= POS_W'(21'(lquo) * 21'(lh_reg) + 21'(lpy_reg));
            rsx_reg  <= POS_W'(18'(rrem) * 18'(rw_reg));
            rsy_reg  <= POS_W'(21'(rquo) * 21'(rh_reg) + 21'(rpy_reg));
            area_reg <= CNT_W'(18'(iw_reg) * 18'(ih_reg));
        end
    end

    // pixel scan
    logic [PIX_W-1:0] lkey_reg, rkey_reg;
    logic [CNT_W-1:0] left_reg;
    logic             hit_now;

    assign hit_now = (in_data[119:88] != lkey_reg) && (in_data[151:120] != rkey_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lkey_reg <= '0;
            rkey_reg <= '0;
            left_reg <= '0;
        end
        else if (cmd.load_win)
        begin
            lkey_reg <= left_b_reg ? key_b_reg : key_a_reg;
            rkey_reg <= left_b_reg ? key_a_reg : key_b_reg;
            left_reg <= area_reg;
        end
        else if (cmd.pix)
            left_reg <= left_reg - CNT_W'(1);
    end

    // output word
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  out_user_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_miss || cmd.load_win || (cmd.pix && sts.pix_end))
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_win)
        begin
            out_user_reg <= 1'b0;
            out_data_reg <= {4'd0, rsy_reg, rsx_reg, lsy_reg, lsx_reg,
                             ih_reg, iw_reg, left_b_reg, 1'b0};
        end
        else if (cmd.load_miss || cmd.pix)
        begin
            out_user_reg <= 1'b1;
            out_data_reg <= {87'd0, cmd.pix && hit_now};
        end
    end

    assign sts.miss     = miss_reg || (iw_reg == '0) || (ih_reg == '0);
    assign sts.div_last = (dcnt_reg == DCNT_W'(DIV_STEPS - 1));
    assign sts.out_free = !out_valid_reg || out_ready;
    assign sts.pix_end  = hit_now || (left_reg == CNT_W'(1));

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_user  = out_user_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/sprite_pixel_collision_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sprite_pixel_collision_top
// Pixel-exact collision test of two color-keyed sprites.
// Begin word: window or miss word after capture, geometry, 12 divider
//   steps, multiply and emit, plus output wait.
// Pixel pair: one word per cycle while the output is free; final word registered in the next cycle.
// Reset (rst_n, async low): idle, registers at defaults, output empty.
// ----------------------------------------------------------------------------
module sprite_pixel_collision_top
    import spcol_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wen,
    input  wire logic [2:0]            cfg_index,
    input  wire logic [31:0]           cfg_data,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // pos_x_a, pos_y_a, frame_a, pos_x_b, pos_y_b, frame_b, pixel_left, pixel_right
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // op
    input  wire logic                  s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // hit, left_is_b, window_width, window_height,
    // left_src_x, left_src_y, right_src_x, right_src_y, zero pad
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    // decided
    output logic                       m_axis_tuser
);

    cmd_t cmd;
    sts_t sts;

    spcol_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_op    (s_axis_tuser),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    spcol_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (s_axis_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser)
    );

endmodule
`default_nettype wire

FILE: bench/sprite_pixel_collision_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_pixel_collision_chk
// Watches the config port and both stream channels, predicts each output
// word of the collision block and compares it field by field.
// ----------------------------------------------------------------------------
module sprite_pixel_collision_chk
    import spcol_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wen,
    input  wire logic [2:0]            cfg_index,
    input  wire logic [31:0]           cfg_data,
    input  wire logic                  s_axis_tvalid,
    input  wire logic                  s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  wire logic                  s_axis_tuser,
    input  wire logic                  m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    input  wire logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  wire logic                  m_axis_tuser,
    output int                         pending,
    output int                         fail_count
);

    typedef struct {
        logic        decided;
        logic        hit;
        logic        left_is_b;
        logic [8:0]  win_w;
        logic [8:0]  win_h;
        logic [15:0] lsx;
        logic [15:0] lsy;
        logic [15:0] rsx;
        logic [15:0] rsy;
    } coll_word_t;

    coll_word_t answers_q[$];

    logic [8:0]  wid_a, hgt_a, wid_b, hgt_b, across_a, across_b;
    logic [31:0] kcol_a, kcol_b;
    logic        in_scan;
    logic [31:0] lkey, rkey;
    logic [16:0] pairs_to_go;

    assign pending = answers_q.size();

    function automatic coll_word_t verdict(input logic h);
        coll_word_t w;
        w = '{default: '0};
        w.decided = 1'b1;
        w.hit     = h;
        return w;
    endfunction

    task automatic predict_begin(input logic [IN_DATA_W-1:0] d);
        int          xa, ya, xb, yb, wa, ha, wb, hb, lx, ly, rx, ry, dx, dy;
        int          lw, lh, rw, rh;
        logic [31:0] lf, rf, lacr, racr, iw, ih, lpy, rpy, t;
        logic        lb;
        coll_word_t  w;
        xa = int'($signed(d[15:0]));
        ya = int'($signed(d[31:16]));
        xb = int'($signed(d[59:44]));
        yb = int'($signed(d[75:60]));
        wa = int'(wid_a > 9'(MAX_SPRITE) ? 9'(MAX_SPRITE) : wid_a);
        ha = int'(hgt_a > 9'(MAX_SPRITE) ? 9'(MAX_SPRITE) : hgt_a);
        wb = int'(wid_b > 9'(MAX_SPRITE) ? 9'(MAX_SPRITE) : wid_b);
        hb = int'(hgt_b > 9'(MAX_SPRITE) ? 9'(MAX_SPRITE) : hgt_b);
        in_scan = 1'b0;
        pairs_to_go = '0;
        if (ya > yb + hb || ya + ha < yb || xa + wa < xb || xa > xb + wb)
        begin
            answers_q.push_back(verdict(1'b0));
            return;
        end
        lb = !(xb > xa);
        if (lb)
        begin
            lx = xb; ly = yb; lw = wb; lh = hb; lf = 32'(d[87:76]); lacr = 32'(across_b);
            rx = xa; ry = ya; rw = wa; rh = ha; rf = 32'(d[43:32]); racr = 32'(across_a);
            lkey = kcol_b; rkey = kcol_a;
        end
        else
        begin
            lx = xa; ly = ya; lw = wa; lh = ha; lf = 32'(d[43:32]); lacr = 32'(across_a);
            rx = xb; ry = yb; rw = wb; rh = hb; rf = 32'(d[87:76]); racr = 32'(across_b);
            lkey = kcol_a; rkey = kcol_b;
        end
        if (lacr == 0) lacr = 32'd1;
        if (racr == 0) racr = 32'd1;
        dx = rx - lx;
        iw = 32'(lw - dx);
        if (iw > 32'(rw)) iw = 32'(rw);
        if (ly > ry)
        begin
            dy = ly - ry;
            lpy = '0;
            rpy = 32'(dy);
            ih = 32'(rh - dy);
            if (ih > 32'(lh)) ih = 32'(lh);
        end
        else
        begin
            dy = ry - ly;
            rpy = '0;
            lpy = 32'(dy);
            ih = 32'(lh - dy);
            if (ih > 32'(rh)) ih = 32'(rh);
        end
        if (iw == 0 || ih == 0)
        begin
            answers_q.push_back(verdict(1'b0));
            return;
        end
        w.decided   = 1'b0;
        w.hit       = 1'b0;
        w.left_is_b = lb;
        w.win_w     = iw[8:0];
        w.win_h     = ih[8:0];
        t = (lf % lacr) * 32'(lw) + 32'(dx);
        w.lsx = t[15:0];
        t = (lf / lacr) * 32'(lh) + lpy;
        w.lsy = t[15:0];
        t = (rf % racr) * 32'(rw);
        w.rsx = t[15:0];
        t = (rf / racr) * 32'(rh) + rpy;
        w.rsy = t[15:0];
        t = iw * ih;
        pairs_to_go = t[16:0];
        in_scan = 1'b1;
        answers_q.push_back(w);
    endtask

    task automatic predict_pair(input logic [IN_DATA_W-1:0] d);
        if (!in_scan)
            return;
        if (d[119:88] != lkey && d[151:120] != rkey)
        begin
            in_scan = 1'b0;
            pairs_to_go = '0;
            answers_q.push_back(verdict(1'b1));
            return;
        end
        if (pairs_to_go > 0)
            pairs_to_go = pairs_to_go - 17'd1;
        if (pairs_to_go == 0)
        begin
            in_scan = 1'b0;
            answers_q.push_back(verdict(1'b0));
        end
    endtask

    task automatic check_field(input string nm, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0h, got %0h", nm, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        coll_word_t e;
        if (!rst_n)
        begin
            wid_a = 9'd16; hgt_a = 9'd16; wid_b = 9'd16; hgt_b = 9'd16;
            across_a = 9'd1; across_b = 9'd1;
            kcol_a = '0; kcol_b = '0;
            in_scan = 1'b0; lkey = '0; rkey = '0; pairs_to_go = '0;
            answers_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (cfg_wen)
            begin
                case (cfg_index)
                    REG_WIDTH_A:  wid_a    = cfg_data[8:0];
                    REG_HEIGHT_A: hgt_a    = cfg_data[8:0];
                    REG_WIDTH_B:  wid_b    = cfg_data[8:0];
                    REG_HEIGHT_B: hgt_b    = cfg_data[8:0];
                    REG_ACROSS_A: across_a = cfg_data[8:0];
                    REG_ACROSS_B: across_b = cfg_data[8:0];
                    REG_KEY_A:    kcol_a   = cfg_data;
                    REG_KEY_B:    kcol_b   = cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser == OP_BEGIN)
                    predict_begin(s_axis_tdata);
                else
                    predict_pair(s_axis_tdata);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (answers_q.size() == 0)
                begin
                    $error("unexpected output word %h / %b", m_axis_tdata, m_axis_tuser);
                    fail_count++;
                end
                else
                begin
                    e = answers_q.pop_front();
                    check_field("decided", 16'(e.decided), 16'(m_axis_tuser));
                    check_field("hit", 16'(e.hit), 16'(m_axis_tdata[0]));
                    check_field("left_is_b", 16'(e.left_is_b), 16'(m_axis_tdata[1]));
                    check_field("window_width", 16'(e.win_w), 16'(m_axis_tdata[10:2]));
                    check_field("window_height", 16'(e.win_h), 16'(m_axis_tdata[19:11]));
                    check_field("left_src_x", e.lsx, m_axis_tdata[35:20]);
                    check_field("left_src_y", e.lsy, m_axis_tdata[51:36]);
                    check_field("right_src_x", e.rsx, m_axis_tdata[67:52]);
                    check_field("right_src_y", e.rsy, m_axis_tdata[83:68]);
                end
            end
        end
    end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the sprite collision block: directed corner cases, then
// random collision tests with pixel scans over several register settings
// and idle/stall patterns. Checking is done in the companion checker.
// ----------------------------------------------------------------------------
module tb;
    import spcol_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wen = 1'b0;
    logic [2:0]            cfg_index = '0;
    logic [31:0]           cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;
    int                    pending;
    int                    fail_count;

    int idle_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;
    int words_sent = 0;
    int sz_w[2] = '{16, 16};
    int sz_h[2] = '{16, 16};
    logic [31:0] keys[2] = '{32'd0, 32'd0};

    always #1 clk = ~clk;

    sprite_pixel_collision_top dut (.*);

    sprite_pixel_collision_chk chk (.*);

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 20000)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send(input logic op, input logic [15:0] xa, input logic [15:0] ya,
                        input logic [11:0] fa, input logic [15:0] xb,
                        input logic [15:0] yb, input logic [11:0] fb,
                        input logic [31:0] pl, input logic [31:0] pr);
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {pr, pl, fb, yb, xb, fa, ya, xa};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic pair(input logic [31:0] pl, input logic [31:0] pr);
        send(OP_PIXEL, 16'($urandom), 16'($urandom), 12'($urandom), 16'($urandom),
             16'($urandom), 12'($urandom), pl, pr);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        if (idx <= REG_HEIGHT_B)
        begin
            if (idx[0]) sz_h[idx[1]] = (val[8:0] > 256) ? 256 : int'(val[8:0]);
            else        sz_w[idx[1]] = (val[8:0] > 256) ? 256 : int'(val[8:0]);
        end
        else if (idx == REG_KEY_A) keys[0] = val;
        else if (idx == REG_KEY_B) keys[1] = val;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic load_setting(input int k);
        logic [8:0] v[6];
        case (k)
            0: v = '{9'd16, 9'd16, 9'd16, 9'd16, 9'd1, 9'd1};
            1: v = '{9'd511, 9'd1, 9'd256, 9'd1, 9'd0, 9'd256};
            2: v = '{9'd0, 9'd5, 9'd3, 9'd0, 9'd511, 9'd2};
            3: v = '{9'd1, 9'd1, 9'd1, 9'd1, 9'd1, 9'd511};
            4: v = '{9'd1, 9'd256, 9'd1, 9'd300, 9'd3, 9'd0};
            default:
                for (int i = 0; i < 6; i++)
                    v[i] = (i < 4) ? 9'($urandom_range(1, 10)) : 9'($urandom_range(0, 20));
        endcase
        write_reg(REG_WIDTH_A, 32'(v[0]));
        write_reg(REG_HEIGHT_A, 32'(v[1]));
        write_reg(REG_WIDTH_B, 32'(v[2]));
        write_reg(REG_HEIGHT_B, 32'(v[3]));
        write_reg(REG_ACROSS_A, 32'(v[4]));
        write_reg(REG_ACROSS_B, 32'(v[5]));
        case (k)
            1: begin write_reg(REG_KEY_A, 32'hFFFF_FFFF); write_reg(REG_KEY_B, 32'h0); end
            3: begin write_reg(REG_KEY_A, 32'h0); write_reg(REG_KEY_B, 32'hFFFF_FFFF); end
            default: begin write_reg(REG_KEY_A, $urandom); write_reg(REG_KEY_B, $urandom); end
        endcase
        cfg_wen <= 1'b0;
    endtask

    task automatic random_test(input int budget);
        int   xa, ya, xb, yb, n, span;
        logic lb, noise;
        logic [31:0] kl, kr, pl, pr;
        noise = ($urandom_range(9) < 2);
        xa = int'($urandom_range(0, 64000)) - 32000;
        ya = int'($urandom_range(0, 64000)) - 32000;
        if (noise)
        begin
            xa = int'($signed(16'($urandom)));
            ya = int'($signed(16'($urandom)));
            xb = int'($signed(16'($urandom)));
            yb = int'($signed(16'($urandom)));
        end
        else
        begin
            xb = xa + int'($urandom_range(0, sz_w[0] + sz_w[1] + 2)) - sz_w[1] - 1;
            yb = ya + int'($urandom_range(0, sz_h[0] + sz_h[1] + 2)) - sz_h[1] - 1;
        end
        send(OP_BEGIN, 16'(xa), 16'(ya), 12'($urandom), 16'(xb), 16'(yb), 12'($urandom),
             $urandom, $urandom);
        lb = !(xb > xa);
        kl = lb ? keys[1] : keys[0];
        kr = lb ? keys[0] : keys[1];
        span = (sz_w[0] > sz_w[1] ? sz_w[0] : sz_w[1]) *
               (sz_h[0] > sz_h[1] ? sz_h[0] : sz_h[1]) + 1;
        if (span > 80) span = 80;
        n = int'($urandom_range(0, span));
        if (n > budget - 1) n = budget - 1;
        for (int i = 0; i < n; i++)
        begin
            pl = $urandom;
            pr = $urandom;
            case ($urandom_range(29))
                0: ;
                1, 2, 3, 4, 5, 6, 7, 8, 9: pl = kl;
                10, 11, 12, 13, 14, 15, 16, 17, 18: pr = kr;
                default: begin pl = kl; pr = kr; end
            endcase
            pair(pl, pr);
        end
    endtask

    initial
    begin
        int lim;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset geometry 16x16, keys 0
        pair(32'h1, 32'h1);
        send(OP_BEGIN, 16'd0, 16'd0, 12'd0, 16'd100, 16'd0, 12'd0, 0, 0);
        send(OP_BEGIN, 16'd0, 16'd0, 12'd0, 16'd0, 16'd17, 12'd0, 0, 0);
        send(OP_BEGIN, 16'd0, 16'd0, 12'd0, 16'd16, 16'd0, 12'd0, 0, 0);
        send(OP_BEGIN, 16'd5, 16'd5, 12'd7, 16'd5, 16'd9, 12'd4095, 0, 0);
        pair(32'h0, 32'hFFFF_FFFF);
        pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(OP_BEGIN, 16'd0, 16'd0, 12'd0, 16'd15, 16'd15, 12'd0, 0, 0);
        pair(32'h0, 32'h0);
        send(OP_BEGIN, 16'h7FF0, 16'h7FF0, 12'd4095, 16'h7FFF, 16'h7FFF, 12'd4095, 0, 0);
        send(OP_BEGIN, 16'h8000, 16'h8000, 12'd0, 16'h8008, 16'h8003, 12'd1, 0, 0);
        pair(32'h0, 32'h5);
        pair(32'hA5A5_5A5A, 32'h0);
        send(OP_BEGIN, 16'h8000, 16'h7FFF, 12'd0, 16'h7FFF, 16'h8000, 12'd0, 0, 0);
        drain();

        for (int k = 0; k < 7; k++)
        begin
            load_setting(k);
            for (int m = 0; m < 4; m++)
            begin
                case (m)
                    0: begin idle_pct = 0;  stall_pct = 0;  end
                    1: begin idle_pct = 87; stall_pct = 0;  end
                    2: begin idle_pct = 0;  stall_pct = 87; end
                    default: begin idle_pct = 15; stall_pct = 15; end
                endcase
                lim = words_sent + 46;
                while (words_sent < lim)
                    random_test(lim - words_sent);
            end
            idle_pct = 0;
            stall_pct = 0;
            drain();
        end

        drain();
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/spcol_pkg.sv
hw/rtl/spcol_div.sv
hw/rtl/spcol_ctrl.sv
hw/rtl/spcol_dp.sv
hw/rtl/sprite_pixel_collision_top.sv
bench/sprite_pixel_collision_chk.sv
bench/tb.sv
